// File: hdl/ctie_pkg.sv
// shared types, constants and codes for the census table ingest/evict unit
`timescale 1ns / 1ps

package ctie_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

  localparam int KEY_W     = 64;
  localparam int OUTCOME_W = 2;
  localparam int TIME_W    = 64;
  localparam int PAYLOAD_W = 64;
  localparam int ACTION_W  = 3;
  localparam int SLOT_W    = 8;
  localparam int ROWCNT_W  = 9;

  // outcome codes; only measured and not-probed drive the table rules
  localparam logic [OUTCOME_W-1:0] OUT_MEASURED   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_NOT_PROBED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_OTHER      = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_RESERVED   = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_IGNORED  = 3'd0,
    ACT_UPDATED  = 3'd1,
    ACT_KEPT     = 3'd2,
    ACT_INSERTED = 3'd3,
    ACT_REPLACED = 3'd4,
    ACT_REFUSED  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [OUTCOME_W-1:0] outcome;
    logic [TIME_W-1:0]    probe_time;
    logic [PAYLOAD_W-1:0] payload;
  } row_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot;
    logic [ROWCNT_W-1:0] row_count;
  } result_t;

endpackage

// File: hdl/ctie_in_if.sv
// input channel: one probe row per transaction
`timescale 1ns / 1ps

interface ctie_in_if;
  logic                            valid;
  logic                            ready;
  logic [ctie_pkg::KEY_W-1:0]      row_key;
  logic [ctie_pkg::OUTCOME_W-1:0]  row_outcome;
  logic [ctie_pkg::TIME_W-1:0]     probe_time;
  logic [ctie_pkg::PAYLOAD_W-1:0]  row_payload;

  modport source (output valid, row_key, row_outcome, probe_time, row_payload, input ready);
  modport sink   (input valid, row_key, row_outcome, probe_time, row_payload, output ready);
endinterface

// File: hdl/ctie_out_if.sv
// result channel: one table action per transaction
`timescale 1ns / 1ps

interface ctie_out_if;
  logic                           valid;
  logic                           ready;
  logic [ctie_pkg::ACTION_W-1:0]  action;
  logic [ctie_pkg::SLOT_W-1:0]    slot;
  logic [ctie_pkg::ROWCNT_W-1:0]  row_count;

  modport source (output valid, action, slot, row_count, input ready);
  modport sink   (input valid, action, slot, row_count, output ready);
endinterface

// File: hdl/ctie_row_mem.sv
// row storage: one write port, one read port with registered read data
`timescale 1ns / 1ps

module ctie_row_mem #(
  parameter int unsigned TABLE_DEPTH = ctie_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ctie_pkg::row_t    wr_row,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output ctie_pkg::row_t    rd_row
);

  ctie_pkg::row_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/ctie_engine.sv
// scan sequencer: key match and victim search over the row memory, then write-back
`timescale 1ns / 1ps

module ctie_engine #(
  parameter int unsigned TABLE_DEPTH = ctie_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctie_pkg::row_t      in_row,
  output logic                res_valid,
  input  logic                res_ready,
  output ctie_pkg::result_t   res,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output ctie_pkg::row_t      wr_row,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  ctie_pkg::row_t      rd_row
);

  localparam int SW = ctie_pkg::SLOT_W;
  localparam int RW = ctie_pkg::ROWCNT_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  ctie_pkg::state_t  state, state_next;
  ctie_pkg::row_t    cur;
  logic [CW-1:0]     count;
  logic [CW-1:0]     iss;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic              match_found;
  logic [AW-1:0]     match_idx;
  logic              match_meas;
  logic [AW-1:0]     victim_idx;
  logic              victim_meas;
  logic [ctie_pkg::TIME_W-1:0] victim_time;
  ctie_pkg::result_t res_q;

  logic              iss_more;
  logic              hit;
  logic              rd_meas;
  ctie_pkg::action_t dec_action;
  logic [AW-1:0]     dec_idx;
  logic [CW-1:0]     count_next;
  logic              dec_write;

  assign iss_more = (iss < count);
  assign rd_meas  = (rd_row.outcome == ctie_pkg::OUT_MEASURED);
  assign hit      = (state == ctie_pkg::ST_SCAN) && pend && (rd_row.key == cur.key);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctie_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_row.key == '0) ? ctie_pkg::ST_DECIDE : ctie_pkg::ST_SCAN;
        end
      end
      ctie_pkg::ST_SCAN: begin
        if (hit || (!iss_more && !pend)) begin
          state_next = ctie_pkg::ST_DECIDE;
        end
      end
      ctie_pkg::ST_DECIDE: state_next = ctie_pkg::ST_REPORT;
      ctie_pkg::ST_REPORT: begin
        if (res_ready) begin
          state_next = ctie_pkg::ST_IDLE;
        end
      end
      default: state_next = ctie_pkg::ST_IDLE;
    endcase
  end

  // outputs and table decision
  always_comb begin
    in_ready   = (state == ctie_pkg::ST_IDLE);
    res_valid  = (state == ctie_pkg::ST_REPORT);
    res        = res_q;
    rd_en      = (state == ctie_pkg::ST_SCAN) && iss_more && !hit;
    rd_addr    = iss[AW-1:0];
    dec_action = ctie_pkg::ACT_IGNORED;
    dec_idx    = '0;
    count_next = count;
    dec_write  = 1'b0;
    priority if (cur.key == '0) begin
      dec_action = ctie_pkg::ACT_IGNORED;
    end else if (match_found) begin
      dec_idx = match_idx;
      if (cur.outcome == ctie_pkg::OUT_NOT_PROBED && match_meas) begin
        dec_action = ctie_pkg::ACT_KEPT;
      end else begin
        dec_action = ctie_pkg::ACT_UPDATED;
        dec_write  = 1'b1;
      end
    end else if (count < DEPTH_CNT) begin
      dec_action = ctie_pkg::ACT_INSERTED;
      dec_idx    = count[AW-1:0];
      count_next = CW'(count + 1'b1);
      dec_write  = 1'b1;
    end else if (victim_meas && cur.outcome == ctie_pkg::OUT_NOT_PROBED) begin
      dec_action = ctie_pkg::ACT_REFUSED;
    end else begin
      dec_action = ctie_pkg::ACT_REPLACED;
      dec_idx    = victim_idx;
      dec_write  = 1'b1;
    end
    wr_en   = (state == ctie_pkg::ST_DECIDE) && dec_write;
    wr_addr = dec_idx;
    wr_row  = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctie_pkg::ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= rd_en;
      if (state == ctie_pkg::ST_DECIDE) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= iss[AW-1:0];
    if (state == ctie_pkg::ST_IDLE && in_valid) begin
      cur         <= in_row;
      iss         <= '0;
      match_found <= 1'b0;
    end
    if (rd_en) begin
      iss <= CW'(iss + 1'b1);
    end
    if (hit) begin
      match_found <= 1'b1;
      match_idx   <= pend_idx;
      match_meas  <= rd_meas;
    end else if (state == ctie_pkg::ST_SCAN && pend) begin
      // measured rows lose the victim seat to any non-measured row, then oldest wins
      if (pend_idx == '0) begin
        victim_idx  <= pend_idx;
        victim_meas <= rd_meas;
        victim_time <= rd_row.probe_time;
      end else if (victim_meas && !rd_meas) begin
        victim_idx  <= pend_idx;
        victim_meas <= 1'b0;
        victim_time <= rd_row.probe_time;
      end else if (victim_meas == rd_meas && rd_row.probe_time < victim_time) begin
        victim_idx  <= pend_idx;
        victim_time <= rd_row.probe_time;
      end
    end
    if (state == ctie_pkg::ST_DECIDE) begin
      res_q.action    <= dec_action;
      res_q.slot      <= (dec_action == ctie_pkg::ACT_REFUSED) ? '0 : SW'(dec_idx);
      res_q.row_count <= RW'(count_next);
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("occupied count above table depth");

  a_no_rw_overlap : assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("row memory read and written in the same cycle");

  a_count_steps : assert property (@(posedge clk) disable iff (rst)
    (state != ctie_pkg::ST_DECIDE) |=> $stable(count))
    else $error("occupied count changed outside the write-back cycle");

  a_scan_addr : assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (iss < count) && (state == ctie_pkg::ST_SCAN))
    else $error("read issued past the occupied rows");

  a_report_holds : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res_q))
    else $error("pending result dropped or changed");

endmodule

// File: hdl/census_table_ingest_evict_unit.sv
// top level of the census table ingest/evict unit
`timescale 1ns / 1ps

// Keeps a bounded table of probe rows keyed by a 64-bit address and returns
// one result transaction per accepted row: ignored (key zero), updated, kept
// measured, inserted, replaced victim or refused. Rows live in a single
// synchronous memory of TABLE_DEPTH entries with one read and one write port.
// An item with a nonzero key is handled by a linear scan that reads one
// stored row per cycle over the occupied rows and stops early when a match
// is found; a zero key skips the scan. The unit works on one item at a
// time, so the next item is accepted only once the last result has been
// handed to the output register. The result sits in an output register, so
// the next item is accepted while a finished result still waits to be taken.
// No clearing pass is needed after reset: only rows below the occupied count
// are ever read.

module census_table_ingest_evict_unit #(
  parameter int unsigned TABLE_DEPTH = ctie_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  ctie_in_if.sink    item,
  ctie_out_if.source result
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  ctie_pkg::row_t    in_row;
  ctie_pkg::result_t eng_res;
  ctie_pkg::result_t out_res;
  logic              eng_valid;
  logic              eng_ready;
  logic              out_valid;

  // memory port wiring
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ctie_pkg::row_t    wr_row;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  ctie_pkg::row_t    rd_row;

  assign in_row.key        = item.row_key;
  assign in_row.outcome    = item.row_outcome;
  assign in_row.probe_time = item.probe_time;
  assign in_row.payload    = item.row_payload;

  ctie_row_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  ctie_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_row    (in_row),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_row    (wr_row),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_row    (rd_row)
  );

  // output register: refilled when empty or when its transaction completes
  assign eng_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_ready) begin
      out_valid <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_ready && eng_valid) begin
      out_res <= eng_res;
    end
  end

  assign result.valid     = out_valid;
  assign result.action    = out_res.action;
  assign result.slot      = out_res.slot;
  assign result.row_count = out_res.row_count;

endmodule
